// ===== rtl/core/atb_pkg.sv =====
package atb_pkg;

  // Field widths
  localparam int unsigned BlockW   = 32;
  localparam int unsigned DivW     = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned OutDataW = 48;

  // Number of quotient bits, one per divider stage
  localparam int unsigned DivSteps = BlockW;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_PART_OFFSET  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PART_SIZE    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LBA_MODE     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SECT_PER_TRK = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HEAD_COUNT   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DRIVE_SELECT = 3'd5;

  // Task-file constants
  localparam logic [ByteW-1:0] CMD_READ  = 8'h20;
  localparam logic [ByteW-1:0] CMD_WRITE = 8'h30;
  localparam logic [ByteW-1:0] DEV_LBA   = 8'hE0;
  localparam logic [ByteW-1:0] DEV_CHS   = 8'hA0;

  // Per-request side information carried along the divider pipelines
  typedef struct packed {
    logic             err;
    logic             is_write;
    logic [ByteW-1:0] sec;
  } atb_side_t;

endpackage

// ===== rtl/core/atb_div_stage.sv =====
module atb_div_stage import atb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [BlockW-1:0] word_i,
  input  logic [DivW-1:0]   rem_i,
  input  atb_side_t         side_i,
  input  logic [DivW-1:0]   divisor_i,
  output logic              vld_o,
  output logic [BlockW-1:0] word_o,
  output logic [DivW-1:0]   rem_o,
  output atb_side_t         side_o
);

  logic              vld_q;
  logic [BlockW-1:0] word_q, word_d;
  logic [DivW-1:0]   rem_q, rem_d;
  atb_side_t         side_q;
  logic [DivW:0]     trial;
  logic [DivW:0]     diff;
  logic              fits;

  // One restoring step: bring down the next dividend bit, try the subtract
  always_comb begin
    trial  = {rem_i, word_i[BlockW-1]};
    diff   = trial - {1'b0, divisor_i};
    fits   = (trial >= {1'b0, divisor_i});
    rem_d  = fits ? diff[DivW-1:0] : trial[DivW-1:0];
    word_d = {word_i[BlockW-2:0], fits};
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
      rem_q  <= rem_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign word_o = word_q;
  assign rem_o  = rem_q;
  assign side_o = side_q;

endmodule

// ===== rtl/core/atb_divider.sv =====
module atb_divider import atb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [BlockW-1:0] dividend_i,
  input  logic [DivW-1:0]   divisor_i,
  input  atb_side_t         side_i,
  output logic              vld_o,
  output logic [BlockW-1:0] quot_o,
  output logic [DivW-1:0]   rem_o,
  output atb_side_t         side_o
);

  logic              vld  [DivSteps+1];
  logic [BlockW-1:0] word [DivSteps+1];
  logic [DivW-1:0]   rem  [DivSteps+1];
  atb_side_t         side [DivSteps+1];

  // Feed the first stage; the remainder starts at zero
  assign vld[0]  = vld_i;
  assign word[0] = dividend_i;
  assign rem[0]  = '0;
  assign side[0] = side_i;

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    atb_div_stage u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en_i),
      .vld_i     (vld[k]),
      .word_i    (word[k]),
      .rem_i     (rem[k]),
      .side_i    (side[k]),
      .divisor_i (divisor_i),
      .vld_o     (vld[k+1]),
      .word_o    (word[k+1]),
      .rem_o     (rem[k+1]),
      .side_o    (side[k+1])
    );
  end

  assign vld_o  = vld[DivSteps];
  assign quot_o = word[DivSteps];
  assign rem_o  = rem[DivSteps];
  assign side_o = side[DivSteps];

  // The remainder always ends below the divisor
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> (rem_o < divisor_i))
    else $error("divider remainder not below divisor");

endmodule

// ===== rtl/core/ata_block_to_taskfile_address.sv =====
// Translates a partition-relative block request into ATA task-file bytes.
// One request word is taken and one result word leaves per clock while the
// result side does not stall; each request passes in order through the front
// register (range check and offset add), the sector divider stages, the head
// divider stages (each divider resolves one quotient bit per stage) and the
// output register. In LBA mode both dividers run with divisor 1, so the
// latency is the same. When the result side stalls, the whole pipeline holds;
// the input stage still takes a word while it is empty. Configuration writes
// are always accepted and must only be made while no request is in flight.
module ata_block_to_taskfile_address import atb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [BlockW-1:0]   s_axis_tdata,   // [31:0] block_number
  input  logic                s_axis_tuser,   // [0] req_type
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] sector_count, [8:1] sector_or_lba_low, [16:9] cyl_low_or_lba_mid,
  // [24:17] cyl_high_or_lba_high, [32:25] device_head, [40:33] command_code,
  // [47:41] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tuser,   // [0] range_error
  // Configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [BlockW-1:0]   cfg_data_i
);

  logic [BlockW-1:0]   offset_q;
  logic [BlockW-1:0]   size_q;
  logic                lba_q;
  logic [DivW-1:0]     spt_q;
  logic [DivW-1:0]     heads_q;
  logic                drive_q;

  logic                en;
  logic                f_vld_q;
  logic                f_err_q;
  logic                f_write_q;
  logic [BlockW-1:0]   f_abs_q;

  logic [DivW-1:0]     div1;
  logic [DivW-1:0]     div2;
  atb_side_t           side0;
  atb_side_t           side1;
  atb_side_t           side1_upd;
  atb_side_t           side2;
  logic                d1_vld;
  logic [BlockW-1:0]   d1_quot;
  logic [DivW-1:0]     d1_rem;
  logic                d2_vld;
  logic [BlockW-1:0]   d2_quot;
  logic [DivW-1:0]     d2_rem;

  logic                o_vld_q;
  logic                o_err_q;
  logic [OutDataW-1:0] o_data_q, o_data_d;
  logic [ByteW-1:0]    drv_bits;
  logic [ByteW-1:0]    b_low, b_mid, b_high, b_dev, b_cmd;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      size_q   <= '0;
      lba_q    <= 1'b0;
      spt_q    <= DivW'(1);
      heads_q  <= DivW'(1);
      drive_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_PART_OFFSET:  offset_q <= cfg_data_i;
        CFG_PART_SIZE:    size_q   <= cfg_data_i;
        CFG_LBA_MODE:     lba_q    <= cfg_data_i[0];
        CFG_SECT_PER_TRK: spt_q    <= cfg_data_i[DivW-1:0];
        CFG_HEAD_COUNT:   heads_q  <= cfg_data_i[DivW-1:0];
        CFG_DRIVE_SELECT: drive_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline advances while the output register is free or being emptied
  assign en            = !o_vld_q || m_axis_tready;
  assign s_axis_tready = en || !f_vld_q;

  // Front stage: range check and offset add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      f_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      f_err_q   <= (s_axis_tdata >= size_q);
      f_write_q <= s_axis_tuser;
      f_abs_q   <= s_axis_tdata + offset_q;
    end
  end

  // Divisors: zero counts as one; LBA passes the address through unchanged
  assign div1 = (lba_q || (spt_q == '0))   ? DivW'(1) : spt_q;
  assign div2 = (lba_q || (heads_q == '0)) ? DivW'(1) : heads_q;

  assign side0 = '{err: f_err_q, is_write: f_write_q, sec: '0};

  // Sector divide: track and sector within track
  atb_divider u_div_sect (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (f_vld_q),
    .dividend_i (f_abs_q),
    .divisor_i  (div1),
    .side_i     (side0),
    .vld_o      (d1_vld),
    .quot_o     (d1_quot),
    .rem_o      (d1_rem),
    .side_o     (side1)
  );

  // Sectors are numbered from one
  always_comb begin
    side1_upd     = side1;
    side1_upd.sec = d1_rem[ByteW-1:0] + ByteW'(1);
  end

  // Head divide: cylinder and head within cylinder
  atb_divider u_div_head (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (d1_vld),
    .dividend_i (d1_quot),
    .divisor_i  (div2),
    .side_i     (side1_upd),
    .vld_o      (d2_vld),
    .quot_o     (d2_quot),
    .rem_o      (d2_rem),
    .side_o     (side2)
  );

  // Assemble the task-file bytes
  always_comb begin
    drv_bits = {3'b000, drive_q, 4'b0000};
    if (lba_q) begin
      b_low  = d2_quot[7:0];
      b_mid  = d2_quot[15:8];
      b_high = d2_quot[23:16];
      b_dev  = d2_quot[31:24] | drv_bits | DEV_LBA;
    end else begin
      b_low  = side2.sec;
      b_mid  = d2_quot[7:0];
      b_high = d2_quot[15:8];
      b_dev  = d2_rem[ByteW-1:0] | drv_bits | DEV_CHS;
    end
    b_cmd = side2.is_write ? CMD_WRITE : CMD_READ;
    if (side2.err) begin
      o_data_d = '0;
    end else begin
      o_data_d = {7'b0000000, b_cmd, b_dev, b_high, b_mid, b_low, 1'b1};
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en) begin
      o_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_err_q  <= side2.err;
      o_data_q <= o_data_d;
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tuser  = o_err_q;
  assign m_axis_tdata  = o_data_q;

  // An error word carries no task-file bytes
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("error result carries non-zero data");

  // A good word always transfers one sector
  a_good_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata[0])
    else $error("good result without sector count");

  // A good word carries a read or write command
  a_good_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |->
      ((m_axis_tdata[40:33] == CMD_READ) || (m_axis_tdata[40:33] == CMD_WRITE)))
    else $error("good result with unknown command");

  // A held front word stays while the pipeline is stalled
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_vld_q && !en) |=> f_vld_q)
    else $error("front word lost during stall");

endmodule
